// ===== hw/rtl/itoa_pkg.sv =====
// Package for integer_to_radix_ascii: widths, word types and character helpers.
package itoa_pkg;

  // Width of the signed input value
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned RADIX_WIDTH = 5;
  localparam int unsigned CHAR_WIDTH  = 8;
  localparam int unsigned DIGIT_WIDTH = 4;

  // Smallest and largest radix that the block honors
  localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = RADIX_WIDTH'(2);
  localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = RADIX_WIDTH'(16);

  // Long division: quotient bits resolved per cycle and chunks per digit
  localparam int unsigned DIV_STEP_BITS = 8;
  localparam int unsigned DIV_CHUNKS    = (VALUE_WIDTH + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int unsigned WORK_W        = DIV_CHUNKS * DIV_STEP_BITS;
  localparam int unsigned CHUNK_CNT_W   = (DIV_CHUNKS > 1) ? $clog2(DIV_CHUNKS) : 1;

  // Digit count: up to VALUE_WIDTH digits (radix two, most negative value)
  localparam int unsigned DIGIT_CNT_W = $clog2(VALUE_WIDTH + 1);

  // Job queue between front and back
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // ASCII codes
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_A_LOWER = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CHAR_F_LOWER = 8'h66;
  localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;

  // Input word
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [RADIX_WIDTH-1:0]        radix;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic [CHAR_WIDTH-1:0] text_char;
    logic                  last;
  } out_word_t;

  // Classified job handed from front to back
  typedef struct packed {
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
    logic [RADIX_WIDTH-1:0] radix;
  } job_t;

  // Handshake between queue and back end
  typedef struct packed {
    logic valid;
  } q_status_t;

  typedef struct packed {
    logic pop;
  } q_ctrl_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } back_state_e;

  // Lower-case hex digit character
  function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
    logic [CHAR_WIDTH-1:0] c;
    if (d < DIGIT_WIDTH'(10)) begin
      c = CHAR_ZERO + CHAR_WIDTH'(d);
    end else begin
      c = CHAR_A_LOWER + CHAR_WIDTH'(d) - CHAR_WIDTH'(10);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/itoa_fifo.sv =====
// Short job queue that decouples the front end from the back end.
module itoa_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  itoa_pkg::job_t   data_i,
  output logic             full_o,
  input  itoa_pkg::q_ctrl_t   ctrl_i,
  output itoa_pkg::q_status_t status_o,
  output itoa_pkg::job_t   data_o
);
  import itoa_pkg::*;

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o         = (cnt_q == QCNT_W'(QDEPTH));
  assign status_o.valid = (cnt_q != '0);
  assign data_o         = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = ctrl_i.pop && status_o.valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/itoa_front.sv =====
// Front end: accepts input words, takes sign and magnitude, clamps the radix.
module itoa_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  itoa_pkg::in_word_t in_word_i,
  input  logic               full_i,
  output logic               push_o,
  output itoa_pkg::job_t     job_o
);
  import itoa_pkg::*;

  logic [VALUE_WIDTH-1:0] raw;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  // classify: sign, unsigned magnitude, radix limited to two..sixteen
  always_comb begin
    raw       = VALUE_WIDTH'(in_word_i.value);
    job_o.neg = raw[VALUE_WIDTH-1];
    job_o.mag = job_o.neg ? (~raw + 1'b1) : raw;
    if (in_word_i.radix < RADIX_MIN) begin
      job_o.radix = RADIX_MIN;
    end else if (in_word_i.radix > RADIX_MAX) begin
      job_o.radix = RADIX_MAX;
    end else begin
      job_o.radix = in_word_i.radix;
    end
  end

endmodule

// ===== hw/rtl/itoa_back.sv =====
// Back end: digit extraction by chunked long division, digit stack, output register.
module itoa_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  itoa_pkg::q_status_t q_status_i,
  input  itoa_pkg::job_t      job_i,
  output itoa_pkg::q_ctrl_t   q_ctrl_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output itoa_pkg::out_word_t out_word_o
);
  import itoa_pkg::*;

  back_state_e            state_q, state_d;
  logic [WORK_W-1:0]      div_q, div_d;
  logic [DIGIT_WIDTH-1:0] rem_q, rem_d;
  logic [RADIX_WIDTH-1:0] radix_q, radix_d;
  logic                   neg_q, neg_d;
  logic [CHUNK_CNT_W-1:0] chunk_q, chunk_d;
  logic [DIGIT_CNT_W-1:0] ndig_q, ndig_d;
  logic [DIGIT_WIDTH-1:0] stack_q [VALUE_WIDTH];
  logic                   out_valid_q, out_valid_d;
  out_word_t              out_word_q, out_word_d;

  logic [DIV_STEP_BITS-1:0] qbits;
  logic [DIGIT_WIDTH-1:0]   rem_next;
  logic [WORK_W-1:0]        quot_next;
  logic                     can_load;
  logic                     push, pop;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign can_load    = !out_valid_q || !out_stall_i;

  // one chunk of restoring division: DIV_STEP_BITS quotient bits per cycle
  always_comb begin
    logic [DIGIT_WIDTH-1:0] r;
    logic [DIGIT_WIDTH:0]   t;
    r     = rem_q;
    qbits = '0;
    for (int k = 0; k < DIV_STEP_BITS; k++) begin
      t = {r, div_q[WORK_W-1-k]};
      if (t >= {1'b0, radix_q[DIGIT_WIDTH-1:0]} + ((radix_q[DIGIT_WIDTH]) ? 5'd16 : 5'd0)) begin
        t = t - radix_q;
        qbits[DIV_STEP_BITS-1-k] = 1'b1;
      end
      r = t[DIGIT_WIDTH-1:0];
    end
    rem_next  = r;
    quot_next = (div_q << DIV_STEP_BITS) | WORK_W'(qbits);
  end

  // sequencer: next state and outputs
  always_comb begin
    state_d      = state_q;
    div_d        = div_q;
    rem_d        = rem_q;
    radix_d      = radix_q;
    neg_d        = neg_q;
    chunk_d      = chunk_q;
    ndig_d       = ndig_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_word_d   = out_word_q;
    q_ctrl_o.pop = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_status_i.valid) begin
          q_ctrl_o.pop = 1'b1;
          div_d        = WORK_W'(job_i.mag);
          rem_d        = '0;
          radix_d      = job_i.radix;
          neg_d        = job_i.neg;
          chunk_d      = '0;
          ndig_d       = '0;
          state_d      = ST_DIV;
        end
      end
      ST_DIV: begin
        div_d   = quot_next;
        rem_d   = rem_next;
        chunk_d = chunk_q + 1'b1;
        if (chunk_q == CHUNK_CNT_W'(DIV_CHUNKS - 1)) begin
          // pass done: remainder is the next digit, quotient feeds the next pass
          push    = 1'b1;
          ndig_d  = ndig_q + 1'b1;
          chunk_d = '0;
          rem_d   = '0;
          if (quot_next == '0) begin
            state_d = neg_q ? ST_SIGN : ST_EMIT;
          end
        end
      end
      ST_SIGN: begin
        if (can_load) begin
          out_valid_d          = 1'b1;
          out_word_d.text_char = CHAR_MINUS;
          out_word_d.last      = 1'b0;
          state_d              = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          out_valid_d          = 1'b1;
          out_word_d.text_char = digit_char(stack_q[0]);
          out_word_d.last      = (ndig_q == DIGIT_CNT_W'(1));
          pop                  = 1'b1;
          ndig_d               = ndig_q - 1'b1;
          if (ndig_q == DIGIT_CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chunk_q     <= '0;
      ndig_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chunk_q     <= chunk_d;
      ndig_q      <= ndig_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    div_q      <= div_d;
    rem_q      <= rem_d;
    radix_q    <= radix_d;
    neg_q      <= neg_d;
    out_word_q <= out_word_d;
  end

  // digit stack: digits arrive least significant first, leave most significant first
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_q[0] <= rem_next;
      for (int i = 1; i < VALUE_WIDTH; i++) begin
        stack_q[i] <= stack_q[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
        stack_q[i] <= stack_q[i+1];
      end
    end
  end

endmodule

// ===== hw/rtl/integer_to_radix_ascii.sv =====
// Top level of integer_to_radix_ascii: front end, job queue and back end.
//
// Converts a signed VALUE_WIDTH-bit integer to its text in radix two to
// sixteen (radix codes below two act as two, above sixteen as sixteen), one
// ASCII word per output handshake, most significant first: '-' for negative
// values, then lower-case digits; last marks the final word. Each digit is
// one long-division pass over DIV_CHUNKS chunks (four at 32 bits), eight
// quotient bits resolved per cycle against the radix; then the characters
// leave one per cycle while the output is not stalled, the digits from the
// digit stack. The front end keeps accepting words into a two-entry job queue
// while the back end works, and the output register lets the next character
// wait without holding up the division.
module integer_to_radix_ascii (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  itoa_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output itoa_pkg::out_word_t out_word_o
);
  import itoa_pkg::*;

  logic      push;
  logic      full;
  job_t      job_in;
  job_t      job_out;
  q_status_t q_status;
  q_ctrl_t   q_ctrl;

  itoa_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job_in)
  );

  itoa_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (job_in),
    .full_o   (full),
    .ctrl_i   (q_ctrl),
    .status_o (q_status),
    .data_o   (job_out)
  );

  itoa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .job_i       (job_out),
    .q_ctrl_o    (q_ctrl),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== hw/rtl/itoa_checker.sv =====
// Port-level checks for integer_to_radix_ascii, bound to the top level.
module itoa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input itoa_pkg::out_word_t out_word_o
);
  import itoa_pkg::*;

  // a stalled word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // a stalled word does not change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("output word changed while stalled");

  // only sign and lower-case hex digits appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.text_char == CHAR_MINUS) ||
                    ((out_word_o.text_char >= CHAR_ZERO) &&
                     (out_word_o.text_char <= CHAR_NINE)) ||
                    ((out_word_o.text_char >= CHAR_A_LOWER) &&
                     (out_word_o.text_char <= CHAR_F_LOWER)))
    else $error("illegal character on output");

  // the sign is always followed by digits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.text_char == CHAR_MINUS) |-> !out_word_o.last)
    else $error("sign word flagged as last");

endmodule

bind integer_to_radix_ascii itoa_checker u_itoa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
